// File: hdl/aes_pkg.sv
// Package: AES-128 types, S-boxes and GF(2^8) helpers.
`default_nettype none
package aes_pkg;

    typedef struct packed {
        logic        func;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_word;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_word;

    localparam int ROUND_COUNT = 10;
    localparam int RK_DEPTH    = ROUND_COUNT + 1;
    localparam int RK_AW       = $clog2(RK_DEPTH);

    localparam logic [7:0] REDUCE_POLY = 8'h1b;
    localparam logic [7:0] RCON_FIRST  = 8'h01;

    localparam logic       FUNC_ENC = 1'b0;
    localparam logic       FUNC_DEC = 1'b1;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? REDUCE_POLY : 8'h00);
    endfunction

    // byte n of a 128-bit state sits in bits 127-8n downto 120-8n
    function automatic logic [7:0] st_byte(input logic [127:0] s, input int n);
        return s[127-8*n -: 8];
    endfunction

endpackage
`default_nettype wire

// File: hdl/aes128_block_cipher.sv
// Top level: AES-128 block cipher with round key memory and APB key port.
//
// Usage: write key_high (0x0) and key_low (0x8) over the APB port (64-bit data),
// then pulse i_start with a block and func (0 encrypt, 1 decrypt) while
// o_busy is low. o_done is high for one cycle; o_result holds the result until the next one.
// One round runs per cycle on a single round unit; round keys are read from an
// 11-entry memory through a registered read in the cycle before use.
// From start to done: load, initial key add, ten rounds, output.
// After reset or a key write, the first block first runs the key expansion,
// one round key written to memory per cycle.
// o_busy drops as o_done rises, so the next block is accepted at the earliest
// at the edge that ends the o_done cycle; no block is taken while another is in flight.
// The receiver cannot stall; results are shown once and must be taken.
// Reset clears control state and the key registers; memory contents are not
// cleared, expansion always fills it before use.
`default_nettype none
module aes128_block_cipher (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire aes_pkg::t_in_word i_data,
    output logic                  o_busy,
    output logic                  o_done,
    output aes_pkg::t_out_word    o_result,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [3:0]            paddr,
    input  wire  [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);
    import aes_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXP  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [63:0]      r_key_high, r_key_low;
    logic             r_keys_ready;
    logic [RK_AW-1:0] r_cnt, n_cnt;
    logic [127:0]     r_exp, n_exp;
    logic [7:0]       r_rcon, n_rcon;
    logic [127:0]     r_st, n_st;
    logic             r_func;
    logic [127:0]     r_blk;
    logic             r_done;
    logic [127:0]     r_res;

    logic [127:0]     rk_mem [RK_DEPTH];
    logic [127:0]     r_rk;
    logic             mem_we;
    logic [RK_AW-1:0] mem_wa, mem_ra;
    logic [127:0]     mem_wd;

    logic             wr_en;
    logic [1:0]       reg_idx;
    logic             accept;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2] >> 1;
    assign accept  = i_start && !o_busy;
    assign o_busy  = (r_state != ST_IDLE);
    assign o_done  = r_done;
    assign o_result = r_res;

    always_comb begin
        unique case (paddr[3])
            1'b0:    prdata = r_key_high;
            default: prdata = r_key_low;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high   <= '0;
            r_key_low    <= '0;
        end else if (wr_en && paddr[2:0] == 3'd0) begin
            case (reg_idx)
                REG_KEY_HIGH: r_key_high <= pwdata;
                REG_KEY_LOW:  r_key_low  <= pwdata;
                default: ;
            endcase
        end
    end

    // last expansion write can collide with the first round key read
    always_ff @(posedge i_clk) begin
        if (mem_we) rk_mem[mem_wa] <= mem_wd;
        r_rk <= (mem_we && mem_wa == mem_ra) ? mem_wd : rk_mem[mem_ra];
    end

    // key schedule step: next round key from previous
    function automatic logic [127:0] next_rk(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t, w0, w1, w2, w3;
        t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic last);
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = SBOX[st_byte(s, 4*c)];
            a1 = SBOX[st_byte(s, 4*((c+1)%4)+1)];
            a2 = SBOX[st_byte(s, 4*((c+2)%4)+2)];
            a3 = SBOX[st_byte(s, 4*((c+3)%4)+3)];
            if (last) begin
                o[127-32*c -: 32] = {a0, a1, a2, a3};
            end else begin
                o[127-32*c -: 32] = {
                    xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                    a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                    a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                    xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
            end
        end
        return o;
    endfunction

    function automatic logic [7:0] mul_e(input logic [7:0] a);
        logic [7:0] x2, x4, x8;
        x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
        return x8 ^ x4 ^ x2;
    endfunction
    function automatic logic [7:0] mul_b(input logic [7:0] a);
        logic [7:0] x2, x4, x8;
        x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
        return x8 ^ x2 ^ a;
    endfunction
    function automatic logic [7:0] mul_d(input logic [7:0] a);
        logic [7:0] x2, x4, x8;
        x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
        return x8 ^ x4 ^ a;
    endfunction
    function automatic logic [7:0] mul_9(input logic [7:0] a);
        logic [7:0] x8;
        x8 = xtime(xtime(xtime(a)));
        return x8 ^ a;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = st_byte(s, 4*c);   a1 = st_byte(s, 4*c+1);
            a2 = st_byte(s, 4*c+2); a3 = st_byte(s, 4*c+3);
            o[127-32*c -: 32] = {
                mul_e(a0) ^ mul_b(a1) ^ mul_d(a2) ^ mul_9(a3),
                mul_9(a0) ^ mul_e(a1) ^ mul_b(a2) ^ mul_d(a3),
                mul_d(a0) ^ mul_9(a1) ^ mul_e(a2) ^ mul_b(a3),
                mul_b(a0) ^ mul_d(a1) ^ mul_9(a2) ^ mul_e(a3)};
        end
        return o;
    endfunction

    // inverse shift rows and inverse S-box
    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127-8*(4*c+r) -: 8] = INV_SBOX[st_byte(s, 4*((c+4-r)%4)+r)];
        return o;
    endfunction

    // state holds s XOR rk for encrypt; decrypt keeps state after inv_mix, or after add_key in the last round
    logic [127:0] dec_t;
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_exp   = r_exp;
        n_rcon  = r_rcon;
        n_st    = r_st;
        mem_we  = 1'b0;
        mem_wa  = r_cnt;
        mem_wd  = r_exp;
        mem_ra  = r_cnt;
        dec_t   = inv_sub_shift(r_st) ^ r_rk;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    if (r_keys_ready) begin
                        n_state = ST_RUN;
                        mem_ra  = i_data.func ? RK_AW'(ROUND_COUNT) : '0;
                        n_cnt   = '0;
                    end else begin
                        n_state = ST_EXP;
                        n_exp   = {r_key_high, r_key_low};
                        n_rcon  = RCON_FIRST;
                    end
                end
            end
            ST_EXP: begin
                mem_we = 1'b1;
                n_exp  = next_rk(r_exp, r_rcon);
                n_rcon = xtime(r_rcon);
                if (r_cnt == RK_AW'(ROUND_COUNT)) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                    mem_ra  = r_func ? RK_AW'(ROUND_COUNT) : '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                // cnt 0: initial add; cnt k: round k
                if (r_cnt == '0) begin
                    n_st = r_blk ^ r_rk;
                end else if (r_func == FUNC_ENC) begin
                    n_st = fwd_round(r_st, r_cnt == RK_AW'(ROUND_COUNT)) ^ r_rk;
                end else begin
                    n_st = (r_cnt == RK_AW'(ROUND_COUNT)) ? dec_t : inv_mix(dec_t);
                end
                mem_ra = r_func ? RK_AW'(ROUND_COUNT - 1) - r_cnt : r_cnt + 1'b1;
                if (r_cnt == RK_AW'(ROUND_COUNT)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_keys_ready <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= (r_state == ST_RUN) && (r_cnt == RK_AW'(ROUND_COUNT));
            if (wr_en) begin
                if (paddr[2:0] == 3'd0 && (reg_idx == REG_KEY_HIGH || reg_idx == REG_KEY_LOW))
                    r_keys_ready <= 1'b0;
            end else if (r_state == ST_EXP && r_cnt == RK_AW'(ROUND_COUNT)) begin
                r_keys_ready <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp  <= n_exp;
        r_rcon <= n_rcon;
        r_st   <= n_st;
        if (accept) begin
            r_func <= i_data.func;
            r_blk  <= {i_data.block_high, i_data.block_low};
        end
        if (r_state == ST_RUN && r_cnt == RK_AW'(ROUND_COUNT))
            r_res <= n_st;
    end

endmodule
`default_nettype wire

// File: hdl/aes_checker.sv
// Checker: port-level timing properties of the AES block, bound to the top level.
`default_nettype none
module aes_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_start,
    input wire o_busy,
    input wire o_done,
    input wire pready
);
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after start");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held more than one cycle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("done while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(o_busy))
        else $error("done without work");
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
    .o_busy(o_busy), .o_done(o_done), .pready(pready)
);
`default_nettype wire
